// ----- rtl/hbc_pkg.sv -----
package hbc_pkg;

    localparam int SLOTS          = 1024;
    localparam int SLOT_W         = $clog2(SLOTS);
    localparam int HEAP_WORDS     = 65536;
    localparam int ADDR_W         = 16;
    localparam int POS_W          = 17;
    localparam int BASE_OFFSET    = 1;
    localparam int COLLECT_BUDGET = 4096;
    localparam int WORD_BYTES     = 8;
    localparam int SLICE_OVERHEAD = 12;
    localparam int BUDGET_WORDS   = COLLECT_BUDGET / WORD_BYTES;
    localparam int RSZ_W          = 18;
    localparam int LW_W           = 18;
    localparam int LIMIT_RESET    = 65536;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_GRAB    = 3'd1,
        OP_RELEASE = 3'd2,
        OP_GET_PTR = 3'd3,
        OP_GET_ID  = 3'd4,
        OP_COLLECT = 3'd5,
        OP_READ    = 3'd6,
        OP_WRITE   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_NO_SLOT   = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_RANGE     = 3'd5
    } status_t;

    typedef struct packed {
        op_t          operation;
        logic [19:0]  size_bytes;
        logic [31:0]  handle;
        logic [15:0]  address;
        logic [15:0]  steps;
        logic [63:0]  write_data;
    } in_req_t;

    typedef struct packed {
        logic [31:0]  result_handle;
        logic [15:0]  payload_address;
        logic [63:0]  read_data;
        logic [2:0]   status;
        logic         collecting;
        logic [16:0]  used_words;
    } out_rsp_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_CR_CHECK, S_CR_PROBE, S_CR_TEST, S_CR_HDR, S_CR_ID,
        S_LK_TAB, S_LK_OFF, S_GI_CHK, S_HDR, S_ID,
        S_RD, S_RD_DATA, S_WR,
        S_CO_INIT, S_CO_PASS, S_CO_LOOP, S_CO_HDR, S_CO_UID, S_CO_COPY,
        S_CO_FILL, S_CO_FRD, S_CO_FWR, S_CO_END,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        DP_NONE, DP_CLEAR, DP_LATCH,
        DP_CR_CHECK, DP_CR_PROBE, DP_CR_TEST, DP_CR_HDR, DP_CR_ID,
        DP_LK_TAB, DP_LK_OFF, DP_GI_CHK, DP_HDR, DP_ID,
        DP_RD, DP_RD_DATA, DP_WR,
        DP_CO_INIT, DP_CO_PASS, DP_CO_LOOP, DP_CO_HDR, DP_CO_UID, DP_CO_COPY,
        DP_CO_FILL, DP_CO_FRD, DP_CO_FWR, DP_CO_END,
        DP_OUT
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic nospace;
        logic table_zero;
        logic tries_done;
        logic range_err;
        logic at_end;
        logic over;
        logic gap;
        logic dead;
        logic copy_last;
        logic more;
    } dp_sts_t;

endpackage

// ----- rtl/hbc_ram.sv -----
module hbc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/hbc_ctrl.sv -----
module hbc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hbc_pkg::op_t     operation,
    output logic             out_valid,
    input  logic             out_ready,
    output hbc_pkg::dp_cmd_t cmd,
    input  hbc_pkg::dp_sts_t sts
);

    hbc_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hbc_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hbc_pkg::S_CLEAR:    if (sts.clr_last) state_next = hbc_pkg::S_IDLE;
            hbc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (operation)
                        hbc_pkg::OP_CREATE:  state_next = hbc_pkg::S_CR_CHECK;
                        hbc_pkg::OP_GRAB,
                        hbc_pkg::OP_RELEASE,
                        hbc_pkg::OP_GET_PTR: state_next = hbc_pkg::S_LK_TAB;
                        hbc_pkg::OP_GET_ID:  state_next = hbc_pkg::S_GI_CHK;
                        hbc_pkg::OP_COLLECT: state_next = hbc_pkg::S_CO_INIT;
                        hbc_pkg::OP_READ:    state_next = hbc_pkg::S_RD;
                        default:             state_next = hbc_pkg::S_WR;
                    endcase
                end
            end
            hbc_pkg::S_CR_CHECK:
                state_next = sts.nospace ? hbc_pkg::S_DONE : hbc_pkg::S_CR_PROBE;
            hbc_pkg::S_CR_PROBE: state_next = hbc_pkg::S_CR_TEST;
            hbc_pkg::S_CR_TEST:
            begin
                if (sts.table_zero)
                    state_next = hbc_pkg::S_CR_HDR;
                else if (sts.tries_done)
                    state_next = hbc_pkg::S_DONE;
                else
                    state_next = hbc_pkg::S_CR_PROBE;
            end
            hbc_pkg::S_CR_HDR:   state_next = hbc_pkg::S_CR_ID;
            hbc_pkg::S_CR_ID:    state_next = hbc_pkg::S_DONE;
            hbc_pkg::S_LK_TAB:   state_next = hbc_pkg::S_LK_OFF;
            hbc_pkg::S_LK_OFF:
                state_next = sts.table_zero ? hbc_pkg::S_DONE : hbc_pkg::S_HDR;
            hbc_pkg::S_GI_CHK:
                state_next = sts.range_err ? hbc_pkg::S_DONE : hbc_pkg::S_HDR;
            hbc_pkg::S_HDR:      state_next = hbc_pkg::S_ID;
            hbc_pkg::S_ID:       state_next = hbc_pkg::S_DONE;
            hbc_pkg::S_RD:       state_next = hbc_pkg::S_RD_DATA;
            hbc_pkg::S_RD_DATA:  state_next = hbc_pkg::S_DONE;
            hbc_pkg::S_WR:       state_next = hbc_pkg::S_DONE;
            hbc_pkg::S_CO_INIT:  state_next = hbc_pkg::S_CO_PASS;
            hbc_pkg::S_CO_PASS:  state_next = hbc_pkg::S_CO_LOOP;
            hbc_pkg::S_CO_LOOP:
            begin
                if (sts.at_end)
                    state_next = hbc_pkg::S_CO_END;
                else if (sts.over)
                    state_next = sts.gap ? hbc_pkg::S_CO_FILL : hbc_pkg::S_CO_END;
                else
                    state_next = hbc_pkg::S_CO_HDR;
            end
            hbc_pkg::S_CO_HDR:   state_next = hbc_pkg::S_CO_UID;
            hbc_pkg::S_CO_UID:
                state_next = (!sts.dead && sts.gap) ? hbc_pkg::S_CO_COPY
                                                    : hbc_pkg::S_CO_LOOP;
            hbc_pkg::S_CO_COPY:
                state_next = sts.copy_last ? hbc_pkg::S_CO_LOOP : hbc_pkg::S_CO_COPY;
            hbc_pkg::S_CO_FILL:  state_next = hbc_pkg::S_CO_FRD;
            hbc_pkg::S_CO_FRD:   state_next = hbc_pkg::S_CO_FWR;
            hbc_pkg::S_CO_FWR:   state_next = hbc_pkg::S_CO_END;
            hbc_pkg::S_CO_END:
                state_next = sts.more ? hbc_pkg::S_CO_PASS : hbc_pkg::S_DONE;
            hbc_pkg::S_DONE:     if (out_free) state_next = hbc_pkg::S_IDLE;
            default:             state_next = hbc_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = hbc_pkg::DP_NONE;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            hbc_pkg::S_CLEAR:    cmd = hbc_pkg::DP_CLEAR;
            hbc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd = hbc_pkg::DP_LATCH;
            end
            hbc_pkg::S_CR_CHECK: cmd = hbc_pkg::DP_CR_CHECK;
            hbc_pkg::S_CR_PROBE: cmd = hbc_pkg::DP_CR_PROBE;
            hbc_pkg::S_CR_TEST:  cmd = hbc_pkg::DP_CR_TEST;
            hbc_pkg::S_CR_HDR:   cmd = hbc_pkg::DP_CR_HDR;
            hbc_pkg::S_CR_ID:    cmd = hbc_pkg::DP_CR_ID;
            hbc_pkg::S_LK_TAB:   cmd = hbc_pkg::DP_LK_TAB;
            hbc_pkg::S_LK_OFF:   cmd = hbc_pkg::DP_LK_OFF;
            hbc_pkg::S_GI_CHK:   cmd = hbc_pkg::DP_GI_CHK;
            hbc_pkg::S_HDR:      cmd = hbc_pkg::DP_HDR;
            hbc_pkg::S_ID:       cmd = hbc_pkg::DP_ID;
            hbc_pkg::S_RD:       cmd = hbc_pkg::DP_RD;
            hbc_pkg::S_RD_DATA:  cmd = hbc_pkg::DP_RD_DATA;
            hbc_pkg::S_WR:       cmd = hbc_pkg::DP_WR;
            hbc_pkg::S_CO_INIT:  cmd = hbc_pkg::DP_CO_INIT;
            hbc_pkg::S_CO_PASS:  cmd = hbc_pkg::DP_CO_PASS;
            hbc_pkg::S_CO_LOOP:  cmd = hbc_pkg::DP_CO_LOOP;
            hbc_pkg::S_CO_HDR:   cmd = hbc_pkg::DP_CO_HDR;
            hbc_pkg::S_CO_UID:   cmd = hbc_pkg::DP_CO_UID;
            hbc_pkg::S_CO_COPY:  cmd = hbc_pkg::DP_CO_COPY;
            hbc_pkg::S_CO_FILL:  cmd = hbc_pkg::DP_CO_FILL;
            hbc_pkg::S_CO_FRD:   cmd = hbc_pkg::DP_CO_FRD;
            hbc_pkg::S_CO_FWR:   cmd = hbc_pkg::DP_CO_FWR;
            hbc_pkg::S_CO_END:   cmd = hbc_pkg::DP_CO_END;
            hbc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    cmd            = hbc_pkg::DP_OUT;
                    out_valid_next = 1'b1;
                end
            end
            default:             cmd = hbc_pkg::DP_NONE;
        endcase
    end

    assign out_valid = out_valid_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == hbc_pkg::S_DONE))
        else $error("response raised outside completion");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != hbc_pkg::S_IDLE)
        else $error("accepted request did not start work");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg == hbc_pkg::S_CLEAR) && state_reg != hbc_pkg::S_CLEAR
        |-> state_reg == hbc_pkg::S_IDLE && $past(sts.clr_last))
        else $error("table clear left early");

endmodule

// ----- rtl/hbc_dpath.sv -----
module hbc_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [16:0]       cfg_wdata,
    input  hbc_pkg::in_req_t  in_data,
    output hbc_pkg::out_rsp_t out_data,
    input  hbc_pkg::dp_cmd_t  cmd,
    output hbc_pkg::dp_sts_t  sts
);

    localparam int SW = hbc_pkg::SLOT_W;
    localparam int AW = hbc_pkg::ADDR_W;
    localparam int PW = hbc_pkg::POS_W;

    // heap and handle table ports
    logic          h_we;
    logic [AW-1:0] h_waddr, h_raddr;
    logic [63:0]   h_wdata, h_rdata;
    logic          t_we;
    logic [SW-1:0] t_waddr, t_raddr;
    logic [15:0]   t_wdata, t_rdata;

    // control registers
    logic [PW-1:0] heap_limit_reg;
    logic [PW-1:0] bump_reg, bump_next;
    logic [PW-1:0] cp_reg, cp_next;
    logic [31:0]   last_id_reg, last_id_next;
    logic [SW-1:0] clr_reg, clr_next;

    // working registers
    hbc_pkg::in_req_t  req_reg, req_next;
    hbc_pkg::out_rsp_t out_reg, out_next;
    logic [SW:0]           try_reg, try_next;
    logic [AW-1:0]         off_reg, off_next;
    logic [63:0]           hdr_reg, hdr_next;
    logic [PW-1:0]         p_reg, p_next;
    logic [PW-1:0]         dst_reg, dst_next;
    logic [hbc_pkg::LW_W-1:0] lw_reg, lw_next;
    logic [PW-1:0]         sz_reg, sz_next;
    logic [PW-1:0]         k_reg, k_next;
    logic                  dead_reg, dead_next;
    logic [15:0]           count_reg, count_next;
    logic                  unlim_reg, unlim_next;
    logic                  again_reg, again_next;
    logic [31:0]           res_reg, res_next;
    logic [15:0]           pay_reg, pay_next;
    logic [63:0]           rd_reg, rd_next;
    logic [2:0]            stat_reg, stat_next;

    // shared arithmetic
    logic [PW-1:0]              lim;
    logic [20:0]                rsz_sum;
    logic [hbc_pkg::RSZ_W-1:0]  rsz;
    logic                       nospace;
    logic [AW-1:0]              cr_id_addr;
    logic [31:0]                id_inc, id_new;
    logic [PW-1:0]              rem;
    logic [31:0]                s_nz;
    logic [PW-1:0]              sz_c;
    logic [31:0]                ref_cnt;

    hbc_ram #(.WIDTH(64), .DEPTH(hbc_pkg::HEAP_WORDS)) u_heap (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    hbc_ram #(.WIDTH(16), .DEPTH(hbc_pkg::SLOTS)) u_table (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    assign lim = (heap_limit_reg > PW'(hbc_pkg::HEAP_WORDS)) ? PW'(hbc_pkg::HEAP_WORDS)
                                                             : heap_limit_reg;
    assign rsz_sum = {1'b0, req_reg.size_bytes}
                   + 21'(hbc_pkg::SLICE_OVERHEAD + hbc_pkg::WORD_BYTES - 1);
    assign rsz     = rsz_sum[20:3];
    assign nospace = ({2'b00, bump_reg} + {1'b0, rsz}) > {2'b00, lim};
    assign cr_id_addr = bump_reg[AW-1:0] + rsz[AW-1:0] - AW'(1);
    assign id_inc  = last_id_reg + 32'd1;
    assign id_new  = (id_inc == 32'd0) ? 32'd1 : id_inc;
    assign rem     = bump_reg - p_reg;
    assign s_nz    = (h_rdata[63:32] == 32'd0) ? 32'd1 : h_rdata[63:32];
    assign sz_c    = (s_nz > {15'd0, rem}) ? rem : s_nz[PW-1:0];
    assign ref_cnt = hdr_reg[31:0];

    assign sts.clr_last   = (clr_reg == SW'(hbc_pkg::SLOTS - 1));
    assign sts.nospace    = nospace;
    assign sts.table_zero = (t_rdata == 16'd0);
    assign sts.tries_done = (try_reg == (SW+1)'(hbc_pkg::SLOTS));
    assign sts.range_err  = (req_reg.address == 16'd0) || ({1'b0, req_reg.address} >= bump_reg);
    assign sts.at_end     = (p_reg >= bump_reg);
    assign sts.over       = (lw_reg > hbc_pkg::LW_W'(hbc_pkg::BUDGET_WORDS));
    assign sts.gap        = (p_reg != dst_reg);
    assign sts.dead       = dead_reg;
    assign sts.copy_last  = (k_reg == sz_reg);
    assign sts.more       = (cp_reg == '0) ? again_reg : (unlim_reg || count_reg != 16'd1);

    always_comb
    begin
        h_we = 1'b0;  h_waddr = '0;  h_wdata = '0;  h_raddr = '0;
        t_we = 1'b0;  t_waddr = '0;  t_wdata = '0;  t_raddr = '0;
        bump_next = bump_reg;  cp_next = cp_reg;  last_id_next = last_id_reg;
        clr_next = clr_reg;  req_next = req_reg;  out_next = out_reg;
        try_next = try_reg;  off_next = off_reg;  hdr_next = hdr_reg;
        p_next = p_reg;  dst_next = dst_reg;  lw_next = lw_reg;  sz_next = sz_reg;
        k_next = k_reg;  dead_next = dead_reg;  count_next = count_reg;
        unlim_next = unlim_reg;  again_next = again_reg;
        res_next = res_reg;  pay_next = pay_reg;  rd_next = rd_reg;  stat_next = stat_reg;

        unique case (cmd)
            hbc_pkg::DP_CLEAR:
            begin
                t_we     = 1'b1;
                t_waddr  = clr_reg;
                clr_next = clr_reg + SW'(1);
            end
            hbc_pkg::DP_LATCH:
            begin
                req_next  = in_data;
                res_next  = '0;
                pay_next  = '0;
                rd_next   = '0;
                stat_next = hbc_pkg::ST_OK;
                try_next  = '0;
            end
            hbc_pkg::DP_CR_CHECK:
                if (nospace) stat_next = hbc_pkg::ST_NO_SPACE;
            hbc_pkg::DP_CR_PROBE:
            begin
                last_id_next = id_new;
                t_raddr      = id_new[SW-1:0];
                try_next     = try_reg + (SW+1)'(1);
            end
            hbc_pkg::DP_CR_TEST:
                if (t_rdata != 16'd0 && sts.tries_done) stat_next = hbc_pkg::ST_NO_SLOT;
            hbc_pkg::DP_CR_HDR:
            begin
                t_we    = 1'b1;
                t_waddr = last_id_reg[SW-1:0];
                t_wdata = bump_reg[AW-1:0];
                h_we    = 1'b1;
                h_waddr = bump_reg[AW-1:0];
                h_wdata = {14'd0, rsz, 32'd0};
                h_raddr = cr_id_addr;
            end
            hbc_pkg::DP_CR_ID:
            begin
                h_we      = 1'b1;
                h_waddr   = cr_id_addr;
                h_wdata   = {last_id_reg, h_rdata[31:0]};
                bump_next = bump_reg + PW'(rsz);
                res_next  = last_id_reg;
            end
            hbc_pkg::DP_LK_TAB:
                t_raddr = req_reg.handle[SW-1:0];
            hbc_pkg::DP_LK_OFF:
            begin
                off_next = t_rdata;
                h_raddr  = t_rdata;
                if (t_rdata == 16'd0) stat_next = hbc_pkg::ST_UNKNOWN;
            end
            hbc_pkg::DP_GI_CHK:
            begin
                off_next = req_reg.address - 16'd1;
                h_raddr  = req_reg.address - 16'd1;
                if (sts.range_err) stat_next = hbc_pkg::ST_RANGE;
            end
            hbc_pkg::DP_HDR:
            begin
                hdr_next = h_rdata;
                h_raddr  = off_reg + h_rdata[47:32] - 16'd1;
            end
            hbc_pkg::DP_ID:
            begin
                case (req_reg.operation)
                    hbc_pkg::OP_GET_ID:
                        res_next = h_rdata[63:32];
                    default:
                    begin
                        if (h_rdata[63:32] != req_reg.handle)
                            stat_next = hbc_pkg::ST_UNKNOWN;
                        else if (req_reg.operation == hbc_pkg::OP_RELEASE)
                        begin
                            if (ref_cnt == 32'd0 || ref_cnt[31])
                                stat_next = hbc_pkg::ST_UNDERFLOW;
                            else
                            begin
                                h_we    = 1'b1;
                                h_waddr = off_reg;
                                h_wdata = {hdr_reg[63:32], ref_cnt - 32'd1};
                            end
                        end
                        else
                        begin
                            // grab bumps the count; both grab and get pointer return payload
                            if (req_reg.operation == hbc_pkg::OP_GRAB)
                            begin
                                h_we    = 1'b1;
                                h_waddr = off_reg;
                                h_wdata = {hdr_reg[63:32], ref_cnt + 32'd1};
                            end
                            pay_next = off_reg + 16'd1;
                        end
                    end
                endcase
            end
            hbc_pkg::DP_RD:
                h_raddr = req_reg.address;
            hbc_pkg::DP_RD_DATA:
                rd_next = h_rdata;
            hbc_pkg::DP_WR:
            begin
                h_we    = 1'b1;
                h_waddr = req_reg.address;
                h_wdata = req_reg.write_data;
            end
            hbc_pkg::DP_CO_INIT:
            begin
                unlim_next = (req_reg.steps == 16'd0);
                again_next = (req_reg.steps == 16'd0) && (cp_reg != '0);
                count_next = req_reg.steps;
                if (cp_reg == '0) cp_next = PW'(hbc_pkg::BASE_OFFSET);
            end
            hbc_pkg::DP_CO_PASS:
            begin
                p_next   = cp_reg;
                dst_next = cp_reg;
                lw_next  = '0;
            end
            hbc_pkg::DP_CO_LOOP:
            begin
                if (sts.at_end)
                begin
                    bump_next = dst_reg;
                    cp_next   = '0;
                end
                else if (sts.over)
                    cp_next = dst_reg;
                else
                    h_raddr = p_reg[AW-1:0];
            end
            hbc_pkg::DP_CO_HDR:
            begin
                sz_next   = sz_c;
                dead_next = (h_rdata[31:0] == 32'd0);
                h_raddr   = p_reg[AW-1:0] + sz_c[AW-1:0] - AW'(1);
            end
            hbc_pkg::DP_CO_UID:
            begin
                k_next = '0;
                if (dead_reg)
                begin
                    lw_next = lw_reg + hbc_pkg::LW_W'(1);
                    if (h_rdata[63:32] != 32'd0)
                    begin
                        t_we    = 1'b1;
                        t_waddr = h_rdata[32 +: SW];
                    end
                    p_next = p_reg + sz_reg;
                end
                else if (sts.gap)
                begin
                    t_we    = 1'b1;
                    t_waddr = h_rdata[32 +: SW];
                    t_wdata = dst_reg[AW-1:0];
                    lw_next = lw_reg + hbc_pkg::LW_W'(1) + hbc_pkg::LW_W'(sz_reg);
                end
                else
                begin
                    lw_next  = lw_reg + hbc_pkg::LW_W'(1);
                    dst_next = dst_reg + sz_reg;
                    p_next   = p_reg + sz_reg;
                end
            end
            hbc_pkg::DP_CO_COPY:
            begin
                // stream: read source word k while writing word k-1
                h_raddr = p_reg[AW-1:0] + k_reg[AW-1:0];
                if (k_reg != '0)
                begin
                    h_we    = 1'b1;
                    h_waddr = dst_reg[AW-1:0] + k_reg[AW-1:0] - AW'(1);
                    h_wdata = h_rdata;
                end
                k_next = k_reg + PW'(1);
                if (sts.copy_last)
                begin
                    dst_next = dst_reg + sz_reg;
                    p_next   = p_reg + sz_reg;
                end
            end
            hbc_pkg::DP_CO_FILL:
            begin
                h_we    = 1'b1;
                h_waddr = dst_reg[AW-1:0];
                h_wdata = {15'd0, p_reg - dst_reg, 32'd0};
            end
            hbc_pkg::DP_CO_FRD:
                h_raddr = p_reg[AW-1:0] - AW'(1);
            hbc_pkg::DP_CO_FWR:
            begin
                h_we    = 1'b1;
                h_waddr = p_reg[AW-1:0] - AW'(1);
                h_wdata = {32'd0, h_rdata[31:0]};
            end
            hbc_pkg::DP_CO_END:
            begin
                if (cp_reg == '0)
                begin
                    if (again_reg)
                    begin
                        cp_next    = PW'(hbc_pkg::BASE_OFFSET);
                        again_next = 1'b0;
                    end
                end
                else if (!unlim_reg)
                    count_next = count_reg - 16'd1;
            end
            hbc_pkg::DP_OUT:
            begin
                out_next.result_handle   = res_reg;
                out_next.payload_address = pay_reg;
                out_next.read_data       = rd_reg;
                out_next.status          = stat_reg;
                out_next.collecting      = (cp_reg != '0);
                out_next.used_words      = bump_reg;
            end
            default:
            begin
                h_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= PW'(hbc_pkg::LIMIT_RESET);
            bump_reg       <= PW'(hbc_pkg::BASE_OFFSET);
            cp_reg         <= '0;
            last_id_reg    <= '0;
            clr_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                heap_limit_reg <= cfg_wdata;
            end
            bump_reg    <= bump_next;
            cp_reg      <= cp_next;
            last_id_reg <= last_id_next;
            clr_reg     <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        out_reg   <= out_next;
        try_reg   <= try_next;
        off_reg   <= off_next;
        hdr_reg   <= hdr_next;
        p_reg     <= p_next;
        dst_reg   <= dst_next;
        lw_reg    <= lw_next;
        sz_reg    <= sz_next;
        k_reg     <= k_next;
        dead_reg  <= dead_next;
        count_reg <= count_next;
        unlim_reg <= unlim_next;
        again_reg <= again_next;
        res_reg   <= res_next;
        pay_reg   <= pay_next;
        rd_reg    <= rd_next;
        stat_reg  <= stat_next;
    end

    assign out_data = out_reg;

    a_bump_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg >= PW'(hbc_pkg::BASE_OFFSET) && bump_reg <= PW'(hbc_pkg::HEAP_WORDS))
        else $error("bump pointer out of heap");

    a_cursor_below_bump: assert property (@(posedge clk) disable iff (!rst_n)
        cp_reg <= bump_reg)
        else $error("collect cursor beyond bump pointer");

    a_copy_moves_down: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == hbc_pkg::DP_CO_COPY |-> dst_reg < p_reg && k_reg <= sz_reg)
        else $error("slice move not downward");

endmodule

// ----- rtl/handle_bump_heap_compactor.sv -----
// Handle-based heap allocator over a 64K x 64-bit word store. One request is
// served at a time; the response sits in an output register, so the next
// request is taken as soon as work finishes even if the response waits.
// After reset the block clears its 1024-entry handle table, one entry per
// cycle, and takes no request until the clear is done (heap_limit writes are
// taken throughout). The handle table and heap memory each have one write
// and one registered read port. Create probes handle slots for a free one
// (up to 1024 probes when the table is crowded). Collect walks the heap one
// slice at a time, streaming the words of each live slice down, and may end
// a pass with a filler slice; each pass stops once roughly 4 KB has been
// visited or moved, and a steps value of 0 runs passes until a full
// collection completes.
module handle_bump_heap_compactor (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [16:0]       cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  hbc_pkg::in_req_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output hbc_pkg::out_rsp_t out_data
);

    hbc_pkg::dp_cmd_t cmd;
    hbc_pkg::dp_sts_t sts;

    // sequencer: decodes each request and steps the datapath through it
    hbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (in_data.operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath: heap and handle memories, pointers, response register
    hbc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
